[sv/amgt_pkg.sv]
package amgt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int CFG_W        = 7;
  localparam int ACT_W        = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEPTH  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BREADTH = 2'd3;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_DIRECTED     = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARC_CHK,
    S_ARC_WR,
    S_ARC_WR2,
    S_ROOT,
    S_RD_ROW,
    S_LATCH,
    S_D_ROW,
    S_D_TOP,
    S_D_TOPW,
    S_B_QRD,
    S_B_QWAIT,
    S_B_EMIT,
    S_B_ROW,
    S_FINISH
  } state_t;

  function automatic vidx_t lowest_index(input row_t x);
    vidx_t r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) r = VIDX_W'(i);
    end
    return r;
  endfunction

endpackage

[sv/amgt_if.sv]
interface amgt_in_if;
  import amgt_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [VIDX_W-1:0] from_vertex;
  logic [VIDX_W-1:0] to_vertex;
  modport source (output valid, action, from_vertex, to_vertex, input ready);
  modport sink (input valid, action, from_vertex, to_vertex, output ready);
endinterface

interface amgt_out_if;
  import amgt_pkg::*;
  logic              valid;
  logic              ready;
  logic [VIDX_W-1:0] vertex;
  logic              status;
  logic              last;
  modport source (output valid, vertex, status, last, input ready);
  modport sink (input valid, vertex, status, last, output ready);
endinterface

[sv/amgt_ram.sv]
module amgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/adjacency_matrix_graph_traversal_core.sv]
// Adjacency bit-matrix graph engine. An arc insert or delete checks the arc
// and, unless it is rejected, writes the row of from_vertex and, in undirected
// mode, the mirror row too; it gives one word. A traversal gives one word per
// visited vertex, last set on the final one. Traversal waits on the registered
// reads of the row memory and the walk stack/queue memory: a depth-first visit
// reads and latches its row, a backtrack first reads the stack top, and a
// breadth-first visit reads the queue head and then its row. Enqueues go one
// per cycle, and the root scan skips one visited index per cycle. One request
// is worked at a time; input ready is high only between requests. Row valid
// flops stand in for clearing the matrix at reset, so there is no clearing
// pass. Write vertex_count and directed_mode only while the block is idle.
module adjacency_matrix_graph_traversal_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [amgt_pkg::CFG_W-1:0] cfg_data,
  amgt_in_if.sink                 in_ch,
  amgt_out_if.source              out_ch
);
  import amgt_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] vertex_count;
  logic             directed_mode;

  logic [ACT_W-1:0] act;
  vidx_t            arc_v, arc_w;

  row_t  row_valid;
  row_t  visited;
  row_t  row_reg;
  logic  rd_valid;
  vidx_t cur_v;
  cnt_t  root;
  cnt_t  sp;
  cnt_t  head, tail;

  logic  pend_valid;
  vidx_t pend_vertex;
  logic  pend_status;

  logic  out_valid;
  vidx_t out_vertex;
  logic  out_status;
  logic  out_last;

  // memories
  logic  adj_we;
  vidx_t adj_waddr, adj_raddr;
  row_t  adj_wdata, adj_rdata;
  logic  wlk_we;
  vidx_t wlk_waddr, wlk_raddr;
  vidx_t wlk_wdata, wlk_rdata;

  amgt_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  amgt_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_walk (
    .clk(clk), .we(wlk_we), .waddr(wlk_waddr), .wdata(wlk_wdata),
    .raddr(wlk_raddr), .rdata(wlk_rdata)
  );

  // derived values
  cnt_t  n_eff;
  row_t  live;
  row_t  adj_row;
  row_t  cand;
  vidx_t pick;
  row_t  arc_bit_w, arc_bit_v;
  logic  arc_bad;
  logic  is_depth;
  logic  can_emit;
  logic  fin_go;

  always_comb begin
    n_eff = (vertex_count > CFG_W'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES)
                                                  : cnt_t'(vertex_count);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = cnt_t'(i) < n_eff;
    end
  end

  assign adj_row   = rd_valid ? adj_rdata : '0;
  assign cand      = row_reg & live & ~visited;
  assign pick      = lowest_index(cand);
  assign arc_bit_w = row_t'(1) << arc_w;
  assign arc_bit_v = row_t'(1) << arc_v;
  assign arc_bad   = ({1'b0, arc_v} >= n_eff) || ({1'b0, arc_w} >= n_eff) ||
                     (arc_v == arc_w);
  assign is_depth  = (act == ACT_DEPTH);
  assign can_emit  = !pend_valid || !out_valid || out_ch.ready;
  assign fin_go    = pend_valid && (!out_valid || out_ch.ready);

  // control strobes
  logic  emit_req;
  vidx_t emit_vertex;
  logic  emit_status;
  logic  go;

  always_comb begin
    emit_req    = 1'b0;
    emit_vertex = cur_v;
    emit_status = 1'b0;
    adj_we      = 1'b0;
    adj_waddr   = arc_v;
    adj_wdata   = adj_row;
    adj_raddr   = cur_v;
    wlk_we      = 1'b0;
    wlk_waddr   = '0;
    wlk_wdata   = pick;
    wlk_raddr   = head[VIDX_W-1:0];
    unique case (state)
      S_IDLE: ;
      S_ARC_CHK: begin
        adj_raddr = arc_v;
        if (arc_bad) begin
          emit_req    = 1'b1;
          emit_vertex = arc_v;
          emit_status = 1'b1;
        end
      end
      S_ARC_WR: begin
        adj_we    = 1'b1;
        adj_waddr = arc_v;
        adj_wdata = (act == ACT_INSERT) ? (adj_row | arc_bit_w) : (adj_row & ~arc_bit_w);
        adj_raddr = arc_w;
        if (directed_mode) begin
          emit_req    = 1'b1;
          emit_vertex = arc_v;
        end
      end
      S_ARC_WR2: begin
        adj_we      = 1'b1;
        adj_waddr   = arc_w;
        adj_wdata   = (act == ACT_INSERT) ? (adj_row | arc_bit_v) : (adj_row & ~arc_bit_v);
        emit_req    = 1'b1;
        emit_vertex = arc_v;
      end
      S_ROOT: begin
        if (root < n_eff && !visited[root[VIDX_W-1:0]]) begin
          wlk_we    = 1'b1;
          wlk_waddr = '0;
          wlk_wdata = root[VIDX_W-1:0];
          if (is_depth) begin
            emit_req    = 1'b1;
            emit_vertex = root[VIDX_W-1:0];
          end
        end
      end
      S_RD_ROW: adj_raddr = cur_v;
      S_LATCH: ;
      S_D_ROW: begin
        if (cand != '0) begin
          emit_req    = 1'b1;
          emit_vertex = pick;
          wlk_we      = 1'b1;
          wlk_waddr   = sp[VIDX_W-1:0];
        end
      end
      S_D_TOP: wlk_raddr = sp[VIDX_W-1:0] - VIDX_W'(1);
      S_D_TOPW: ;
      S_B_QRD: wlk_raddr = head[VIDX_W-1:0];
      S_B_QWAIT: ;
      S_B_EMIT: begin
        emit_req    = 1'b1;
        emit_vertex = cur_v;
        adj_raddr   = cur_v;
      end
      S_B_ROW: begin
        if (cand != '0) begin
          wlk_we    = 1'b1;
          wlk_waddr = tail[VIDX_W-1:0];
        end
      end
      S_FINISH: ;
      default: ;
    endcase
    go = !emit_req || can_emit;
    if (!go) begin
      adj_we = 1'b0;
      wlk_we = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = (in_ch.action == ACT_INSERT || in_ch.action == ACT_DELETE)
                       ? S_ARC_CHK : S_ROOT;
        end
      end
      S_ARC_CHK: state_next = arc_bad ? S_FINISH : S_ARC_WR;
      S_ARC_WR:  state_next = directed_mode ? S_FINISH : S_ARC_WR2;
      S_ARC_WR2: state_next = S_FINISH;
      S_ROOT: begin
        if (root >= n_eff) state_next = S_FINISH;
        else if (!visited[root[VIDX_W-1:0]] && go)
          state_next = is_depth ? S_RD_ROW : S_B_QRD;
      end
      S_RD_ROW: state_next = S_LATCH;
      S_LATCH:  state_next = is_depth ? S_D_ROW : S_B_ROW;
      S_D_ROW: begin
        if (cand != '0) begin
          if (go) state_next = S_RD_ROW;
        end else if (sp == cnt_t'(1)) begin
          state_next = S_ROOT;
        end else begin
          state_next = S_D_TOP;
        end
      end
      S_D_TOP:   state_next = S_D_TOPW;
      S_D_TOPW:  state_next = S_RD_ROW;
      S_B_QRD:   state_next = (head == tail) ? S_ROOT : S_B_QWAIT;
      S_B_QWAIT: state_next = S_B_EMIT;
      S_B_EMIT:  if (go) state_next = S_LATCH;
      S_B_ROW:   if (cand == '0) state_next = S_B_QRD;
      S_FINISH:  if (!pend_valid || fin_go) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= CFG_W'(MAX_VERTICES);
      directed_mode <= 1'b0;
      row_valid     <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= row_valid[adj_raddr];
      if (cfg_we) begin
        if (cfg_index == REG_VERTEX_COUNT) vertex_count <= cfg_data;
        if (cfg_index == REG_DIRECTED)     directed_mode <= cfg_data[0];
      end
      if (adj_we) row_valid[adj_waddr] <= 1'b1;
      // hold the newest word back one step so that last can be set on it
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (emit_req && can_emit) begin
        pend_valid <= 1'b1;
        if (pend_valid) out_valid <= 1'b1;
      end
      if (state == S_FINISH && fin_go) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (emit_req && can_emit) begin
      pend_vertex <= emit_vertex;
      pend_status <= emit_status;
      if (pend_valid) begin
        out_vertex <= pend_vertex;
        out_status <= pend_status;
        out_last   <= 1'b0;
      end
    end
    if (state == S_FINISH && fin_go) begin
      out_vertex <= pend_vertex;
      out_status <= pend_status;
      out_last   <= 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        act     <= in_ch.action;
        arc_v   <= in_ch.from_vertex;
        arc_w   <= in_ch.to_vertex;
        visited <= '0;
        root    <= '0;
        sp      <= '0;
        head    <= '0;
        tail    <= '0;
      end
      S_ROOT: begin
        if (root < n_eff) begin
          if (visited[root[VIDX_W-1:0]]) begin
            root <= root + cnt_t'(1);
          end else if (go) begin
            visited[root[VIDX_W-1:0]] <= 1'b1;
            cur_v <= root[VIDX_W-1:0];
            sp    <= cnt_t'(1);
            head  <= '0;
            tail  <= cnt_t'(1);
          end
        end
      end
      S_LATCH: row_reg <= adj_row;
      S_D_ROW: begin
        if (cand != '0) begin
          if (go) begin
            visited[pick] <= 1'b1;
            cur_v <= pick;
            sp    <= sp + cnt_t'(1);
          end
        end else begin
          sp <= sp - cnt_t'(1);
          if (sp == cnt_t'(1)) root <= root + cnt_t'(1);
        end
      end
      S_D_TOPW:  cur_v <= wlk_rdata;
      S_B_QRD:   if (head == tail) root <= root + cnt_t'(1);
      S_B_QWAIT: cur_v <= wlk_rdata;
      S_B_EMIT:  if (go) head <= head + cnt_t'(1);
      S_B_ROW: begin
        if (cand != '0) begin
          visited[pick] <= 1'b1;
          tail <= tail + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.vertex = out_vertex;
  assign out_ch.status = out_status;
  assign out_ch.last   = out_last;

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !pend_valid)
    else $error("request taken with a word still pending");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_ROW) |-> (sp != '0 && sp <= cnt_t'(MAX_VERTICES)))
    else $error("walk stack depth out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_QRD || state == S_B_ROW) |-> (head <= tail))
    else $error("queue head passed tail");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !pend_valid) |=> (state == S_IDLE))
    else $error("finish did not return to idle");

endmodule
